// ===== src/mpss_pkg.sv =====
// ============================================================================
// mpss_pkg - shared types and constants of the signature scanner
// Signature text, start/end masks of the match vector, character codes and
// the verdict encoding used by the step logic and the top level.
// ============================================================================
`default_nettype none

package mpss_pkg;

	// Signature list, laid end to end; one match bit per signature character
	localparam int SIG_COUNT      = 13;
	localparam int SIG_CHAR_TOTAL = 100;

	localparam int SIG_LEN [SIG_COUNT] = '{7, 8, 11, 9, 12, 10, 11, 11, 7, 8, 2, 2, 2};

	// First character sits in the top byte
	localparam logic [8*SIG_CHAR_TOTAL-1:0] SIG_TEXT = {
		"<script", "</script", "javascript:", "vbscript:",
		"union select", "drop table", "insert into", "delete from",
		" or 1=1", " and 1=1", "--", "/*", "*/"
	};

	// Character codes
	localparam logic [7:0] CHAR_TAB     = 8'h09;
	localparam logic [7:0] CHAR_LF      = 8'h0A;
	localparam logic [7:0] CHAR_CR      = 8'h0D;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	typedef enum logic [1:0] {
		VERDICT_SAFE  = 2'd0,
		VERDICT_CTRL  = 2'd1,
		VERDICT_MATCH = 2'd2
	} verdict_t;

	// Bit i set: prefix of length (i - signature start + 1) is a suffix of the input
	typedef logic [SIG_CHAR_TOTAL-1:0] match_vec_t;

	typedef struct packed {
		match_vec_t act;
		verdict_t   verdict;
	} scan_state_t;

	// Mark the first (want_last = 0) or last character of every signature
	function automatic match_vec_t sig_edge_mask(input logic want_last);
		match_vec_t m;
		int pos;
		m   = '0;
		pos = 0;
		for (int k = 0; k < SIG_COUNT; k++) begin
			if (want_last) begin
				m[pos + SIG_LEN[k] - 1] = 1'b1;
			end else begin
				m[pos] = 1'b1;
			end
			pos += SIG_LEN[k];
		end
		return m;
	endfunction

	localparam match_vec_t SIG_FIRST = sig_edge_mask(1'b0);
	localparam match_vec_t SIG_LAST  = sig_edge_mask(1'b1);

	// Character at position i of the concatenated signature text
	function automatic logic [7:0] sig_char(input int i);
		return SIG_TEXT[8*(SIG_CHAR_TOTAL-1-i) +: 8];
	endfunction

endpackage

`default_nettype wire

// ===== src/multi_pattern_signature_scanner.sv =====
// ============================================================================
// multi_pattern_signature_scanner - streaming signature and control check
// Scans a string byte by byte for thirteen attack signatures, case folded.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall): one byte per item in data_byte,
//   final_byte high on the last byte of a string.
//   Output channel (out_valid / out_stall): one result per byte. verdict is
//   0 while the string looks safe, 1 once a bad control byte was seen, 2 once
//   a signature matched; it holds until the end of the string. string_done
//   repeats final_byte and closes the string.
//   Each byte passes an input register, then the result register. One
//   item per cycle is sustained while out_stall is low; the match vector
//   and verdict are computed from the registered byte.
//   While out_stall is high with a result waiting, one more item is taken
//   into the input register, then in_stall rises until the result leaves.
//   Reset clears both stages, the match vector and the verdict; the scanner
//   starts at the beginning of a string. After each final byte it does so
//   again.
// ============================================================================
`default_nettype none

module multi_pattern_signature_scanner (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] verdict,
	output logic       string_done
);
	import mpss_pkg::*;

	logic        valid_s1;
	logic [7:0]  data_byte_s1;
	logic        final_byte_s1;
	logic        valid_s2;
	verdict_t    verdict_s2;
	logic        string_done_s2;
	scan_state_t state_q;
	scan_state_t state_nxt;
	logic        out_free;
	logic        adv;

	// Handshake: result register frees up when empty or being taken
	assign out_free = !valid_s2 || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_byte_s1  <= data_byte;
			final_byte_s1 <= final_byte;
		end
	end

	mpss_step u_step (
		.data_byte (data_byte_s1),
		.cur       (state_q),
		.nxt       (state_nxt)
	);

	// Scan state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q  <= '{act: '0, verdict: VERDICT_SAFE};
		end else begin
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
			if (adv) begin
				if (final_byte_s1) begin
					state_q <= '{act: '0, verdict: VERDICT_SAFE};
				end else begin
					state_q <= state_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			verdict_s2     <= state_nxt.verdict;
			string_done_s2 <= final_byte_s1;
		end
	end

	assign out_valid   = valid_s2;
	assign verdict     = verdict_s2;
	assign string_done = string_done_s2;

	// Checks
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("in_stall raised with an empty input register");

	a_clear_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && final_byte_s1) |=> (state_q.verdict == VERDICT_SAFE && state_q.act == '0))
		else $error("scan state not cleared after final byte");

	a_verdict_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !final_byte_s1 && state_q.verdict != VERDICT_SAFE)
		|=> (state_q.verdict == $past(state_q.verdict)))
		else $error("verdict changed inside a string");

	a_result_tracks_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !final_byte_s1) |=> (verdict_s2 == state_q.verdict))
		else $error("result verdict differs from held verdict");

endmodule

`default_nettype wire

// ===== src/mpss_step.sv =====
// ============================================================================
// mpss_step - next-state logic for one byte
// Classifies the byte, folds case and advances the bit-parallel match
// vector; a completed signature or a bad control byte sets the verdict.
// ============================================================================
`default_nettype none

module mpss_step (
	input  logic [7:0]            data_byte,
	input  mpss_pkg::scan_state_t cur,
	output mpss_pkg::scan_state_t nxt
);
	import mpss_pkg::*;

	logic       bad_ctrl;
	logic       high_byte;
	logic [7:0] folded;
	match_vec_t prev;
	match_vec_t hit;

	// Byte classification and case folding
	always_comb begin
		bad_ctrl  = (data_byte < CHAR_SPACE) && (data_byte != CHAR_TAB) &&
		            (data_byte != CHAR_LF) && (data_byte != CHAR_CR);
		high_byte = data_byte[7];
		if (data_byte >= CHAR_UPPER_A && data_byte <= CHAR_UPPER_Z) begin
			folded = data_byte + CASE_OFFSET;
		end else begin
			folded = data_byte;
		end
	end

	// Each bit extends its predecessor; signature starts always may begin
	always_comb begin
		prev = {cur.act[SIG_CHAR_TOTAL-2:0], 1'b1};
		for (int i = 0; i < SIG_CHAR_TOTAL; i++) begin
			hit[i] = (folded == sig_char(i)) && (SIG_FIRST[i] || prev[i]);
		end
	end

	// Sticky verdict: once set, the rest of the string is ignored
	always_comb begin
		nxt = cur;
		if (cur.verdict == VERDICT_SAFE) begin
			if (bad_ctrl) begin
				nxt.verdict = VERDICT_CTRL;
			end else if (high_byte) begin
				nxt.act = '0;
			end else begin
				nxt.act = hit;
				if (|(hit & SIG_LAST)) begin
					nxt.verdict = VERDICT_MATCH;
				end
			end
		end
	end

endmodule

`default_nettype wire
